// ===== hdl/qdil_pkg.sv =====
// Package for the quadrature decoder with index latch.
// Beat types, register indexes, field widths and the x4 step decode table.
// No dependencies.
`default_nettype none

package qdil_pkg;

    // Field widths fixed by the port definition
    localparam int POS_W       = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // Default storage widths for the top level parameters
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int HOLD_WIDTH_DEF  = 16;

    // Register reset values
    localparam logic                  INDEX_ENABLE_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] HOLD_TICKS_RST   = 16'd120;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS   = 1'b1;

    // Input beat: one sample of the three pins
    typedef struct packed {
        logic chan_a;
        logic chan_b;
        logic index_level;
    } qdil_in_t;

    // Output beat: reported position and capture flag
    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    index_flag;
    } qdil_out_t;

    // Count change for code {new B, new A, old B, old A}, 3-bit two's complement.
    // A jump of both channels counts as two steps in the A-edge direction.
    function automatic logic signed [2:0] step_delta(input logic [3:0] code);
        logic signed [2:0] d;
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14:   d = 3'sd1;
            4'd2, 4'd4, 4'd11, 4'd13:  d = -3'sd1;
            4'd3, 4'd12:               d = 3'sd2;
            4'd6, 4'd9:                d = -3'sd2;
            default:                   d = 3'sd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/qdil_core.sv =====
// Decoder core: configuration registers, live count, index latch and hold timer.
// Produces one output beat for each accepted sample. Depends on qdil_pkg.
`default_nettype none

module qdil_core #(
    parameter int COUNT_WIDTH = qdil_pkg::COUNT_WIDTH_DEF,
    parameter int HOLD_WIDTH  = qdil_pkg::HOLD_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [qdil_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [qdil_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               step,
    input  wire qdil_pkg::qdil_in_t                 sample,
    output qdil_pkg::qdil_out_t                     result
);

    logic                            index_enable_reg;
    logic [qdil_pkg::CFG_DATA_W-1:0] hold_ticks_reg;

    logic [1:0]             prev_ab_reg,       prev_ab_next;
    logic [COUNT_WIDTH-1:0] live_count_reg,    live_count_next;
    logic [COUNT_WIDTH-1:0] latched_count_reg, latched_count_next;
    logic [COUNT_WIDTH-1:0] position_reg,      position_next;
    logic [HOLD_WIDTH-1:0]  hold_left_reg,     hold_left_next;
    logic                   flag_reg,          flag_next;

    logic [3:0]        code;
    logic signed [2:0] delta;
    logic              hold_idle;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_enable_reg <= qdil_pkg::INDEX_ENABLE_RST;
            hold_ticks_reg   <= qdil_pkg::HOLD_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qdil_pkg::CFG_INDEX_ENABLE: index_enable_reg <= cfg_data[0];
                qdil_pkg::CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode the AB transition and advance the live count
    assign code          = {sample.chan_b, sample.chan_a, prev_ab_reg};
    assign delta         = qdil_pkg::step_delta(code);
    assign prev_ab_next  = code[3:2];
    assign live_count_next = live_count_reg
                           + {{(COUNT_WIDTH-3){delta[2]}}, delta};
    assign hold_idle     = (hold_left_reg == '0);

    // Latch on index level, run the hold timer, or follow the live count
    always_comb
    begin
        latched_count_next = latched_count_reg;
        position_next      = position_reg;
        hold_left_next     = hold_left_reg;
        flag_next          = flag_reg;
        if (index_enable_reg)
        begin
            if (sample.index_level && hold_idle)
            begin
                latched_count_next = live_count_next;
                position_next      = live_count_next;
                hold_left_next     = HOLD_WIDTH'(hold_ticks_reg);
                flag_next          = 1'b1;
            end
            else if (!hold_idle)
            begin
                hold_left_next = hold_left_reg - HOLD_WIDTH'(1);
            end
            else
            begin
                flag_next     = 1'b0;
                position_next = live_count_next;
            end
        end
        else
        begin
            position_next = live_count_next;
        end
    end

    // Commit state on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ab_reg       <= '0;
            live_count_reg    <= '0;
            latched_count_reg <= '0;
            position_reg      <= '0;
            hold_left_reg     <= '0;
            flag_reg          <= 1'b0;
        end
        else if (step)
        begin
            prev_ab_reg       <= prev_ab_next;
            live_count_reg    <= live_count_next;
            latched_count_reg <= latched_count_next;
            position_reg      <= position_next;
            hold_left_reg     <= hold_left_next;
            flag_reg          <= flag_next;
        end
    end

    // Output beat from the updated state
    assign result.position   = qdil_pkg::POS_W'(position_next);
    assign result.index_flag = flag_next;

endmodule

`default_nettype wire

// ===== hdl/qdil_out_buf.sv =====
// Two-entry output buffer: a ring of two entries with read and write pointers.
// Decouples the output stall from sample acceptance. Depends on qdil_pkg.
`default_nettype none

module qdil_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire qdil_pkg::qdil_out_t  push_data,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output qdil_pkg::qdil_out_t       out_data
);

    qdil_pkg::qdil_out_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg, count_next;
    logic                pop;

    assign pop       = out_valid && !out_stall;
    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/quadrature_decoder_index_latch.sv =====
// Top level of the x4 quadrature decoder with index latch.
// Instantiates qdil_core and qdil_out_buf; types from qdil_pkg.
//
//   channel | direction | handshake           | beat
//   in      | input     | in_valid / in_stall  | qdil_in_t  (chan_a, chan_b, index_level)
//   out     | output    | out_valid / out_stall| qdil_out_t (position, index_flag)
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One sample is taken per clock while in_stall is low; its result is buffered for out.
// The count, latch and hold timer update together in qdil_core on each accepted sample.
// A two-entry output buffer holds results; in_stall is high while both entries wait.
// Reset is asynchronous and clears all state but buffer data; registers go to defaults.
`default_nettype none

module quadrature_decoder_index_latch #(
    parameter int COUNT_WIDTH = qdil_pkg::COUNT_WIDTH_DEF,
    parameter int HOLD_WIDTH  = qdil_pkg::HOLD_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [qdil_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [qdil_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire qdil_pkg::qdil_in_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output qdil_pkg::qdil_out_t                     out_data
);

    logic                buf_full;
    logic                accept;
    qdil_pkg::qdil_out_t result;

    // Accept a sample whenever the buffer has room
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    qdil_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .HOLD_WIDTH  (HOLD_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .sample    (in_data),
        .result    (result)
    );

    qdil_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
